/* rtl/sivl_pkg.sv */
// sivl_pkg: shared types and constants for the sorted index value locator
// holds item and result structs, command and register codes, sequencer states
// no dependencies
package sivl_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 1024;
	localparam int KEY_W               = 64;
	localparam int OFFS_W              = 32;
	localparam int SLOT_W              = 10;
	localparam int COUNT_W             = 11;
	localparam int CFG_IDX_W           = 1;
	localparam int CFG_DATA_W          = 32;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_POSITION = 1'b1;

	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] entry_index;
		logic [KEY_W-1:0]  search_key;
		logic [OFFS_W-1:0] entry_offset;
	} item_t;

	typedef struct packed {
		logic              found;
		logic [OFFS_W-1:0] begin_pos;
		logic [OFFS_W-1:0] value_length;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_LEN
	} state_t;

endpackage

/* rtl/sivl_table.sv */
// sivl_table: key and offset storage of the sorted index value locator
// one write port and one registered read port shared by both arrays
// depends on sivl_pkg
module sivl_table
	import sivl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [KEY_W-1:0]  wr_key,
	input  logic [OFFS_W-1:0] wr_offs,
	input  logic [AW-1:0]     rd_addr,
	output logic [KEY_W-1:0]  rd_key,
	output logic [OFFS_W-1:0] rd_offs
);

	logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
	logic [OFFS_W-1:0] offs_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]  <= wr_key;
			offs_mem[wr_addr] <= wr_offs;
		end
	end

	always_ff @(posedge clk) begin
		rd_key  <= key_mem[rd_addr];
		rd_offs <= offs_mem[rd_addr];
	end

endmodule

/* rtl/sorted_index_value_locator_unit.sv */
// sorted_index_value_locator_unit: top level, binary search over a sorted key table
// holds the configuration registers, the search sequencer and the result register
// depends on sivl_pkg and sivl_table
//
// usage:
//   an item is taken when start is high and busy is low. a write item
//   (cmd = write) stores key and offset at entry_index and gives
//   no result; slots at or above the table depth are ignored. a lookup item
//   searches the first key_count entries (saturated to the table depth) and
//   reads one entry per cycle through the single read port. on a hit that is
//   not the last entry it also reads the following entry to fetch the next
//   offset, from which the length is taken. busy stays high until the result
//   cycle, in which the next item may already be taken.
//   with key_count zero the miss comes out in the cycle after the item.
//   each result is shown on result for exactly one cycle with done high;
//   the receiver cannot stall, so there is no hold-off.
//   configuration writes (cfg_valid, always ready) go to key_count (index 0) or end_position
//   (index 1) and must be made while the block is idle; the block does not enforce this.
//   reset clears the sequencer, the strobe and both registers; table undefined until written
module sorted_index_value_locator_unit
	import sivl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t            state_q, state_d;
	logic              done_q, done_d;
	result_t           result_q, result_d;
	logic [COUNT_W-1:0] key_count_q;
	logic [OFFS_W-1:0] end_pos_q;

	logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d, n_q, n_d, n_sat;
	logic [AW-1:0]     mid_q, mid_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [OFFS_W-1:0] begin_q, begin_d;
	logic [CW-1:0]     mid_ext, mid_inc;
	logic [CW:0]       span_sum;
	logic              slot_ok;

	logic              wr_en;
	logic [AW-1:0]     rd_addr;
	logic [KEY_W-1:0]  rd_key;
	logic [OFFS_W-1:0] rd_offs;

	sivl_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(item.entry_index)),
		.wr_key  (item.search_key),
		.wr_offs (item.entry_offset),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_offs (rd_offs)
	);

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign result    = result_q;

	assign n_sat   = (32'(key_count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
	                                                       : CW'(key_count_q);
	assign slot_ok = (32'(item.entry_index) < 32'(TABLE_DEPTH));
	assign mid_ext = CW'(mid_q);
	assign mid_inc = CW'(mid_q) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			end_pos_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_COUNT:    key_count_q <= cfg_data[COUNT_W-1:0];
				CFG_END_POSITION: end_pos_q   <= cfg_data[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		n_q      <= n_d;
		mid_q    <= mid_d;
		key_q    <= key_d;
		begin_q  <= begin_d;
		result_q <= result_d;
	end

	always_comb begin
		state_d  = state_q;
		done_d   = 1'b0;
		result_d = result_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		n_d      = n_q;
		mid_d    = mid_q;
		key_d    = key_q;
		begin_d  = begin_q;
		rd_addr  = mid_q;
		wr_en    = 1'b0;
		span_sum = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.cmd == CMD_WRITE) begin
						wr_en = slot_ok;
					end else begin
						key_d   = item.search_key;
						n_d     = n_sat;
						lo_d    = '0;
						hi_d    = n_sat;
						mid_d   = AW'(n_sat >> 1);
						rd_addr = mid_d;
						if (n_sat == '0) begin
							done_d   = 1'b1;
							result_d = '0;
						end else begin
							state_d = ST_PROBE;
						end
					end
				end
			end
			ST_PROBE: begin
				if (rd_key == key_q) begin
					begin_d = rd_offs;
					if (mid_inc == n_q) begin
						done_d   = 1'b1;
						result_d = '{found: 1'b1, begin_pos: rd_offs,
						             value_length: end_pos_q - rd_offs};
						state_d  = ST_IDLE;
					end else begin
						rd_addr = AW'(mid_inc);
						state_d = ST_LEN;
					end
				end else begin
					if (key_q < rd_key) begin
						hi_d = mid_ext;
					end else begin
						lo_d = mid_inc;
					end
					span_sum = {1'b0, lo_d} + {1'b0, hi_d};
					if (lo_d < hi_d) begin
						mid_d   = span_sum[AW:1];
						rd_addr = mid_d;
					end else begin
						done_d   = 1'b1;
						result_d = '0;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_LEN: begin
				done_d   = 1'b1;
				result_d = '{found: 1'b1, begin_pos: begin_q,
				             value_length: rd_offs - begin_q};
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/sivl_checker.sv */
// sivl_checker: port-level checks for the sorted index value locator
// bound to sorted_index_value_locator_unit at the end of this file
// depends on sivl_pkg
module sivl_checker
	import sivl_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	// a miss carries zero offset and length
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.begin_pos == '0 && result.value_length == '0))
		else $error("miss with nonzero offset or length");

	// a write item gives no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_WRITE) |=> !done)
		else $error("result after a write item");

	// a lookup item either starts a search or answers at once
	a_lookup_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_LOOKUP) |=> (busy || done))
		else $error("lookup item dropped");

	// the result appears only once the search has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");

endmodule

bind sorted_index_value_locator_unit sivl_checker u_sivl_checker (.*);
